[hdl/rgh_pkg.sv]
// Package with the beat types and fixed constants of the repeat gap histogram unit.
`default_nettype none
package rgh_pkg;

    localparam int SYMBOL_FIELD_BITS = 4;
    localparam int BIN_FIELD_BITS    = 8;
    localparam int COUNT_FIELD_BITS  = 32;
    localparam int MAX_GAP_BITS      = 8;

    localparam logic [MAX_GAP_BITS-1:0] MAX_GAP_RESET = 8'd128;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_operation;

    typedef struct packed {
        t_operation                   operation;
        logic [SYMBOL_FIELD_BITS-1:0] symbol;
        logic [BIN_FIELD_BITS-1:0]    bin_select;
    } t_in_item;

    typedef struct packed {
        logic [BIN_FIELD_BITS-1:0]   bin_index;
        logic [COUNT_FIELD_BITS-1:0] bin_count;
    } t_out_item;

endpackage
`default_nettype wire

[hdl/rgh_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module rgh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

[hdl/rgh_result_queue.sv]
// Small result queue that decouples the histogram pipeline from the output channel.
`default_nettype none
module rgh_result_queue (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire rgh_pkg::t_out_item                  i_data,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output rgh_pkg::t_out_item                       o_data,
    output logic [rgh_pkg::QUEUE_LEVEL_BITS-1:0]     o_level
);

    rgh_pkg::t_out_item r_entry [rgh_pkg::QUEUE_DEPTH];
    logic [rgh_pkg::QUEUE_PTR_BITS-1:0]   r_wr_ptr;
    logic [rgh_pkg::QUEUE_PTR_BITS-1:0]   r_rd_ptr;
    logic [rgh_pkg::QUEUE_LEVEL_BITS-1:0] r_level;
    logic                                 pop;

    assign o_valid = (r_level != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_level = r_level;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + rgh_pkg::QUEUE_PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + rgh_pkg::QUEUE_PTR_BITS'(1);
            end
            if (i_push && !pop) begin
                r_level <= r_level + rgh_pkg::QUEUE_LEVEL_BITS'(1);
            end else if (pop && !i_push) begin
                r_level <= r_level - rgh_pkg::QUEUE_LEVEL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

[hdl/repeat_gap_histogram_unit.sv]
// Top level of the repeat gap histogram unit: gap tracking and histogram pipeline.
// Throughput is one beat per cycle while ready is high; each beat reads the last-position RAM
// and a counted push takes one histogram read-modify-write, with forwarding between
// back-to-back updates of a bin. Read results pass stage 1, stage 2 and the result queue.
// Ready drops at four reads held. After reset the histogram RAM is cleared one bin per cycle,
// with input ready low; max_gap resets to 128 and may be written during the clear.
`default_nettype none
module repeat_gap_histogram_unit #(
    parameter int SYMBOL_BITS   = 4,
    parameter int HIST_DEPTH    = 256,
    parameter int POSITION_BITS = 32,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [rgh_pkg::MAX_GAP_BITS-1:0]     i_cfg_wr_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire rgh_pkg::t_in_item                    i_in_data,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output rgh_pkg::t_out_item                        o_out_data
);

    localparam int SYMBOL_COUNT = 1 << SYMBOL_BITS;
    localparam int HADDR_BITS   = $clog2(HIST_DEPTH);
    localparam int CMP_BITS     = (POSITION_BITS > HADDR_BITS + 1) ? POSITION_BITS
                                                                  : HADDR_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [rgh_pkg::MAX_GAP_BITS-1:0] r_max_gap;
    logic [POSITION_BITS-1:0]         r_position;
    logic [SYMBOL_COUNT-1:0]          r_seen;
    logic                             r_clearing;
    logic [HADDR_BITS-1:0]            r_clr_addr;

    logic                             accept;
    logic                             push_acc;
    logic [SYMBOL_BITS-1:0]           sym;

    logic                             r_s1_push;
    logic                             r_s1_read;
    logic                             r_s1_seen;
    logic [POSITION_BITS-1:0]         r_s1_pos;
    logic [rgh_pkg::BIN_FIELD_BITS-1:0] r_s1_sel;

    logic [POSITION_BITS-1:0]         last_pos;
    logic [POSITION_BITS-1:0]         gap;
    logic [CMP_BITS-1:0]              gap_ext;
    logic [CMP_BITS-1:0]              sel_ext;
    logic                             hit;
    logic                             sel_in_range;
    logic [HADDR_BITS-1:0]            hist_rd_addr;

    logic                             r_s2_inc;
    logic                             r_s2_read;
    logic                             r_s2_in_range;
    logic [HADDR_BITS-1:0]            r_s2_addr;
    logic [rgh_pkg::BIN_FIELD_BITS-1:0] r_s2_sel;

    logic [COUNT_BITS-1:0]            hist_rd_data;
    logic [COUNT_BITS-1:0]            cur_count;
    logic [COUNT_BITS-1:0]            new_count;
    logic                             r_wb_valid;
    logic [HADDR_BITS-1:0]            r_wb_addr;
    logic [COUNT_BITS-1:0]            r_wb_data;

    logic                             hist_wr_en;
    logic [HADDR_BITS-1:0]            hist_wr_addr;
    logic [COUNT_BITS-1:0]            hist_wr_data;

    rgh_pkg::t_out_item               result;
    logic [rgh_pkg::QUEUE_LEVEL_BITS-1:0] queue_level;
    logic [rgh_pkg::QUEUE_LEVEL_BITS:0]   credit_used;

    // Stage 0: accept, seen flags and last-position RAM access.
    assign credit_used = (rgh_pkg::QUEUE_LEVEL_BITS + 1)'(queue_level)
                       + (rgh_pkg::QUEUE_LEVEL_BITS + 1)'(r_s1_read)
                       + (rgh_pkg::QUEUE_LEVEL_BITS + 1)'(r_s2_read);
    assign o_in_ready  = !r_clearing
                       && (credit_used < (rgh_pkg::QUEUE_LEVEL_BITS + 1)'(rgh_pkg::QUEUE_DEPTH));
    assign accept      = i_in_valid && o_in_ready;
    assign push_acc    = accept && (i_in_data.operation == rgh_pkg::OP_PUSH);
    assign sym         = SYMBOL_BITS'(i_in_data.symbol);

    rgh_ram #(
        .WIDTH (POSITION_BITS),
        .DEPTH (SYMBOL_COUNT)
    ) u_last_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (push_acc),
        .i_wr_addr (sym),
        .i_wr_data (r_position),
        .i_rd_addr (sym),
        .o_rd_data (last_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap  <= rgh_pkg::MAX_GAP_RESET;
            r_position <= '0;
            r_seen     <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_push  <= 1'b0;
            r_s1_read  <= 1'b0;
            r_s2_inc   <= 1'b0;
            r_s2_read  <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_gap <= i_cfg_wr_data;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + HADDR_BITS'(1);
                if (r_clr_addr == HADDR_BITS'(HIST_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (push_acc) begin
                r_position  <= r_position + POSITION_BITS'(1);
                r_seen[sym] <= 1'b1;
            end
            r_s1_push  <= push_acc;
            r_s1_read  <= accept && (i_in_data.operation == rgh_pkg::OP_READ);
            r_s2_inc   <= hit;
            r_s2_read  <= r_s1_read;
            r_wb_valid <= r_s2_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_seen     <= r_seen[sym];
        r_s1_pos      <= r_position;
        r_s1_sel      <= i_in_data.bin_select;
        r_s2_addr     <= hist_rd_addr;
        r_s2_sel      <= r_s1_sel;
        r_s2_in_range <= sel_in_range;
        r_wb_addr     <= r_s2_addr;
        r_wb_data     <= new_count;
    end

    // Stage 1: gap computation and histogram read.
    always_comb begin
        gap          = r_s1_pos - last_pos - POSITION_BITS'(1);
        gap_ext      = CMP_BITS'(gap);
        sel_ext      = CMP_BITS'(r_s1_sel);
        hit          = r_s1_push && r_s1_seen
                     && (gap_ext <= CMP_BITS'(r_max_gap))
                     && (gap_ext < CMP_BITS'(HIST_DEPTH));
        sel_in_range = sel_ext < CMP_BITS'(HIST_DEPTH);
        hist_rd_addr = r_s1_push ? gap_ext[HADDR_BITS-1:0] : sel_ext[HADDR_BITS-1:0];
    end

    rgh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (hist_wr_data),
        .i_rd_addr (hist_rd_addr),
        .o_rd_data (hist_rd_data)
    );

    // Stage 2: forward the previous update, increment with saturation, write back.
    always_comb begin
        cur_count = (r_wb_valid && (r_wb_addr == r_s2_addr)) ? r_wb_data : hist_rd_data;
        new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
        hist_wr_en   = r_clearing || r_s2_inc;
        hist_wr_addr = r_clearing ? r_clr_addr : r_s2_addr;
        hist_wr_data = r_clearing ? '0 : new_count;
        result.bin_index = r_s2_sel;
        result.bin_count = r_s2_in_range ? rgh_pkg::COUNT_FIELD_BITS'(cur_count)
                                         : '0;
    end

    rgh_result_queue u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_read),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data),
        .o_level (queue_level)
    );

endmodule
`default_nettype wire
